// ----- hw/rtl/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the LRU key-value cache: table sizes and field widths.
// Depends on nothing; used by lru_key_value_cache.
package lkvc_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int CAP_RESET  = 16;

    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int CNT_BITS = $clog2(ENTRIES + 1);
    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    typedef logic [IDX_BITS-1:0]   t_idx;
    typedef logic [CNT_BITS-1:0]   t_cnt;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;

endpackage

// ----- hw/rtl/lru_key_value_cache.sv -----
`timescale 1ns / 1ps
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkvc_pkg for sizes and types.

// Each request is a get or a put and yields one response. A single key compare and
// rank unit is swept across the table by a small sequencer: one pass finds the hit,
// the first free entry and the least recent entry, a decide step writes the entry,
// and a second pass updates the recency ranks when an entry was used or filled (a
// get that misses skips it). A new request is taken only once the last one has put
// its response into the output register. The response sits in that register, so the
// next request is taken while it waits; a request that finishes while that register
// is still full holds in its last state until the response is taken. The capacity
// register is written through its own channel, which is always ready; the user must
// write it only while no request is in flight, as the block does not enforce this.
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_BITS-1:0] i_cfg_capacity_in_use,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic                i_req_type,
    input  t_key                i_req_key,
    input  t_value              i_req_value,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output logic                o_found,
    output t_value              o_read_value,
    output logic                o_evicted,
    output t_key                o_evicted_key
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_TOUCH  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]          r_state, n_state;
    t_idx                r_ptr, n_ptr;
    logic [CAP_BITS-1:0] r_cap, n_cap;
    t_cnt                r_occ, n_occ;

    logic          r_valid [ENTRIES];
    logic          n_valid [ENTRIES];
    t_key          r_key   [ENTRIES];
    t_key          n_key   [ENTRIES];
    t_value        r_value [ENTRIES];
    t_value        n_value [ENTRIES];
    t_idx          r_rank  [ENTRIES];
    t_idx          n_rank  [ENTRIES];

    logic   r_req_put, n_req_put;
    t_key   r_req_key, n_req_key;
    t_value r_req_value, n_req_value;

    logic r_hit_found, n_hit_found;
    t_idx r_hit_slot, n_hit_slot;
    t_idx r_hit_rank, n_hit_rank;
    logic r_free_found, n_free_found;
    t_idx r_free_slot, n_free_slot;
    logic r_lru_found, n_lru_found;
    t_idx r_lru_slot, n_lru_slot;
    t_idx r_lru_rank, n_lru_rank;
    t_key r_lru_key, n_lru_key;

    t_idx r_slot, n_slot;
    t_cnt r_thr, n_thr;

    logic   r_res_found, n_res_found;
    t_value r_res_value, n_res_value;
    logic   r_res_evicted, n_res_evicted;
    t_key   r_res_evk, n_res_evk;

    logic   r_out_valid, n_out_valid;
    logic   r_out_found, n_out_found;
    t_value r_out_value, n_out_value;
    logic   r_out_evicted, n_out_evicted;
    t_key   r_out_evk, n_out_evk;

    logic                cur_v;
    t_key                cur_k;
    t_idx                cur_r;
    logic [CMP_BITS-1:0] cap_eff;
    logic                do_evict;
    logic                last;

    assign o_cfg_ready   = 1'b1;
    assign o_req_ready   = (r_state == S_IDLE);
    assign o_rsp_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_read_value  = r_out_value;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evk;

    always_comb begin
        cur_v = r_valid[r_ptr];
        cur_k = r_key[r_ptr];
        cur_r = r_rank[r_ptr];
        last  = (r_ptr == IDX_BITS'(ENTRIES - 1));

        if (r_cap == '0) begin
            cap_eff = CMP_BITS'(1);
        end else if (CMP_BITS'(r_cap) > CMP_BITS'(ENTRIES)) begin
            cap_eff = CMP_BITS'(ENTRIES);
        end else begin
            cap_eff = CMP_BITS'(r_cap);
        end
        do_evict = (CMP_BITS'(r_occ) >= cap_eff) && (r_occ != '0);

        n_state       = r_state;
        n_ptr         = r_ptr;
        n_cap         = r_cap;
        n_occ         = r_occ;
        n_valid       = r_valid;
        n_key         = r_key;
        n_value       = r_value;
        n_rank        = r_rank;
        n_req_put     = r_req_put;
        n_req_key     = r_req_key;
        n_req_value   = r_req_value;
        n_hit_found   = r_hit_found;
        n_hit_slot    = r_hit_slot;
        n_hit_rank    = r_hit_rank;
        n_free_found  = r_free_found;
        n_free_slot   = r_free_slot;
        n_lru_found   = r_lru_found;
        n_lru_slot    = r_lru_slot;
        n_lru_rank    = r_lru_rank;
        n_lru_key     = r_lru_key;
        n_slot        = r_slot;
        n_thr         = r_thr;
        n_res_found   = r_res_found;
        n_res_value   = r_res_value;
        n_res_evicted = r_res_evicted;
        n_res_evk     = r_res_evk;
        n_out_valid   = r_out_valid;
        n_out_found   = r_out_found;
        n_out_value   = r_out_value;
        n_out_evicted = r_out_evicted;
        n_out_evk     = r_out_evk;

        if (i_cfg_valid) begin
            n_cap = i_cfg_capacity_in_use;
        end

        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req_put    = i_req_type;
                    n_req_key    = i_req_key;
                    n_req_value  = i_req_value;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_lru_found  = 1'b0;
                    n_ptr        = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cur_v && (cur_k == r_req_key) && !r_hit_found) begin
                    n_hit_found = 1'b1;
                    n_hit_slot  = r_ptr;
                    n_hit_rank  = cur_r;
                end
                if (!cur_v && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_slot  = r_ptr;
                end
                if (cur_v && (!r_lru_found || (cur_r > r_lru_rank))) begin
                    n_lru_found = 1'b1;
                    n_lru_slot  = r_ptr;
                    n_lru_rank  = cur_r;
                    n_lru_key   = cur_k;
                end
                n_ptr = r_ptr + 1'b1;
                if (last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_res_found   = 1'b0;
                n_res_value   = '0;
                n_res_evicted = 1'b0;
                n_res_evk     = '0;
                n_ptr         = '0;
                n_state       = S_FINISH;
                if (r_hit_found) begin
                    n_res_found = 1'b1;
                    n_slot      = r_hit_slot;
                    n_thr       = CNT_BITS'(r_hit_rank);
                    n_state     = S_TOUCH;
                    if (r_req_put) begin
                        n_value[r_hit_slot] = r_req_value;
                    end else begin
                        n_res_value = r_value[r_hit_slot];
                    end
                end else if (r_req_put) begin
                    if (do_evict) begin
                        n_res_evicted       = 1'b1;
                        n_res_evk           = r_lru_key;
                        n_slot              = r_lru_slot;
                        n_thr               = CNT_BITS'(r_lru_rank);
                        n_key[r_lru_slot]   = r_req_key;
                        n_value[r_lru_slot] = r_req_value;
                        n_state             = S_TOUCH;
                    end else if (r_free_found) begin
                        n_slot               = r_free_slot;
                        n_thr                = CNT_BITS'(ENTRIES);
                        n_valid[r_free_slot] = 1'b1;
                        n_key[r_free_slot]   = r_req_key;
                        n_value[r_free_slot] = r_req_value;
                        n_occ                = r_occ + 1'b1;
                        n_state              = S_TOUCH;
                    end
                end
            end
            S_TOUCH: begin
                if (r_ptr == r_slot) begin
                    n_rank[r_ptr] = '0;
                end else if (cur_v && (CNT_BITS'(cur_r) < r_thr)) begin
                    n_rank[r_ptr] = cur_r + 1'b1;
                end
                n_ptr = r_ptr + 1'b1;
                if (last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_found   = r_res_found;
                    n_out_value   = r_res_value;
                    n_out_evicted = r_res_evicted;
                    n_out_evk     = r_res_evk;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_cap       <= CAP_BITS'(CAP_RESET);
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_rank[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_cap       <= n_cap;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
            r_valid     <= n_valid;
            r_rank      <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_value       <= n_value;
        r_req_put     <= n_req_put;
        r_req_key     <= n_req_key;
        r_req_value   <= n_req_value;
        r_hit_found   <= n_hit_found;
        r_hit_slot    <= n_hit_slot;
        r_hit_rank    <= n_hit_rank;
        r_free_found  <= n_free_found;
        r_free_slot   <= n_free_slot;
        r_lru_found   <= n_lru_found;
        r_lru_slot    <= n_lru_slot;
        r_lru_rank    <= n_lru_rank;
        r_lru_key     <= n_lru_key;
        r_slot        <= n_slot;
        r_thr         <= n_thr;
        r_res_found   <= n_res_found;
        r_res_value   <= n_res_value;
        r_res_evicted <= n_res_evicted;
        r_res_evk     <= n_res_evk;
        r_out_found   <= n_out_found;
        r_out_value   <= n_out_value;
        r_out_evicted <= n_out_evicted;
        r_out_evk     <= n_out_evk;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: directed and random get/put requests
// against a behavioral LRU table, with random idling and backpressure on both channels.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
module tb_top;
    import lkvc_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 2 * ENTRIES + 8;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct {
        logic   found;
        t_value read_value;
        logic   evicted;
        t_key   evicted_key;
    } t_cache_response;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CAP_BITS-1:0] i_cfg_capacity_in_use;
    logic                i_req_valid;
    logic                o_req_ready;
    logic                i_req_type;
    t_key                i_req_key;
    t_value              i_req_value;
    logic                o_rsp_valid;
    logic                i_rsp_ready;
    logic                o_found;
    t_value              o_read_value;
    logic                o_evicted;
    t_key                o_evicted_key;

    lru_key_value_cache u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_capacity_in_use (i_cfg_capacity_in_use),
        .i_req_valid           (i_req_valid),
        .o_req_ready           (o_req_ready),
        .i_req_type            (i_req_type),
        .i_req_key             (i_req_key),
        .i_req_value           (i_req_value),
        .o_rsp_valid           (o_rsp_valid),
        .i_rsp_ready           (i_rsp_ready),
        .o_found               (o_found),
        .o_read_value          (o_read_value),
        .o_evicted             (o_evicted),
        .o_evicted_key         (o_evicted_key)
    );

    // Shadow copy of the cache table.
    logic                tbl_valid [ENTRIES];
    t_key                tbl_key   [ENTRIES];
    t_value              tbl_value [ENTRIES];
    int                  tbl_rank  [ENTRIES];
    int                  tbl_count;
    logic [CAP_BITS-1:0] tbl_capacity;

    t_cache_response expected_responses[$];
    int  mismatch_count;
    int  cycle_count;
    bit  sender_gaps_on;
    bit  receiver_gaps_on;
    int  receiver_hold_cycles;
    t_key key_pool[32];
    int  key_pool_size;

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int effective_capacity();
        if (tbl_capacity == 0) return 1;
        if (tbl_capacity > ENTRIES) return ENTRIES;
        return int'(tbl_capacity);
    endfunction

    function automatic void promote_entry(int s);
        int r;
        r = tbl_rank[s];
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && i != s && tbl_rank[i] < r) tbl_rank[i]++;
        end
        tbl_rank[s] = 0;
    endfunction

    function automatic t_cache_response compute_cache_response(logic is_put, t_key key,
                                                               t_value val);
        t_cache_response rsp;
        int hit;
        int slot;
        int best;
        rsp = '{found: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
        hit = -1;
        slot = -1;
        best = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_key[i] == key && hit < 0) hit = i;
        end
        if (hit >= 0) begin
            rsp.found = 1'b1;
            if (is_put) tbl_value[hit] = val;
            else rsp.read_value = tbl_value[hit];
            promote_entry(hit);
        end else if (is_put) begin
            if (tbl_count >= effective_capacity() && tbl_count > 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && (slot < 0 || tbl_rank[i] > best)) begin
                        slot = i;
                        best = tbl_rank[i];
                    end
                end
                rsp.evicted = 1'b1;
                rsp.evicted_key = tbl_key[slot];
                tbl_key[slot] = key;
                tbl_value[slot] = val;
                promote_entry(slot);
            end else begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!tbl_valid[i] && slot < 0) slot = i;
                end
                if (slot >= 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (tbl_valid[i]) tbl_rank[i]++;
                    end
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot] = key;
                    tbl_value[slot] = val;
                    tbl_rank[slot] = 0;
                    tbl_count++;
                end
            end
        end
        return rsp;
    endfunction

    task automatic send_request(logic req_type, t_key key, t_value val);
        int gap;
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge i_clk);
                i_req_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_req_valid = 1'b1;
        i_req_type = req_type;
        i_req_key = key;
        i_req_value = val;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        expected_responses.push_back(compute_cache_response(req_type, key, val));
    endtask

    task automatic wait_all_responses();
        @(negedge i_clk);
        i_req_valid = 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_BITS-1:0] cap);
        wait_all_responses();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_capacity_in_use = cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tbl_capacity = cap;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic void build_key_pool();
        key_pool_size = effective_capacity() + int'($urandom_range(1, 8));
        if (key_pool_size > 32) key_pool_size = 32;
        for (int i = 0; i < 32; i++) key_pool[i] = t_key'($urandom);
    endfunction

    function automatic t_key pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, key_pool_size - 1)];
        return t_key'($urandom);
    endfunction

    function automatic t_value pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return t_value'($urandom);
    endfunction

    task automatic send_random_request();
        send_request(logic'($urandom_range(0, 1)), pick_key(), pick_value());
    endtask

    task automatic test_capacity_one();
        write_capacity(5'd1);
        send_request(REQ_PUT, 16'h0000, 32'hFFFF_FFFF);
        send_request(REQ_GET, 16'h0000, 32'h1234_5678);
        send_request(REQ_PUT, 16'hFFFF, 32'h0000_0000);
        send_request(REQ_GET, 16'h0000, 32'h0000_0000);
        send_request(REQ_GET, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(REQ_PUT, 16'hFFFF, 32'hA5A5_5A5A);
        send_request(REQ_GET, 16'hFFFF, 32'h0000_0000);
    endtask

    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_request(REQ_PUT, 16'h1234, 32'h0BAD_F00D);
        send_request(REQ_GET, 16'hFFFF, 32'h0000_0000);
        send_request(REQ_GET, 16'h1234, 32'h0000_0000);
    endtask

    task automatic test_fill_and_evict();
        write_capacity(5'd4);
        send_request(REQ_PUT, 16'h0001, 32'h1111_1111);
        send_request(REQ_PUT, 16'h0002, 32'h2222_2222);
        send_request(REQ_PUT, 16'h0003, 32'h3333_3333);
        send_request(REQ_GET, 16'h1234, 32'h0000_0000);
        send_request(REQ_PUT, 16'h0004, 32'h4444_4444);
        send_request(REQ_PUT, 16'h0002, 32'h2222_AAAA);
        send_request(REQ_PUT, 16'h0005, 32'h5555_5555);
        send_request(REQ_GET, 16'h0001, 32'h0000_0000);
        send_request(REQ_GET, 16'h0002, 32'h0000_0000);
        send_request(REQ_PUT, 16'h8000, 32'h8000_0000);
        send_request(REQ_GET, 16'h0003, 32'h0000_0000);
    endtask

    task automatic test_response_backpressure();
        wait_all_responses();
        build_key_pool();
        receiver_hold_cycles = 400;
        repeat (20) send_random_request();
        wait_all_responses();
    endtask

    task automatic test_random_requests(int n_items, logic [CAP_BITS-1:0] cap);
        int pause_at;
        write_capacity(cap);
        build_key_pool();
        pause_at = $urandom_range(n_items / 4, 3 * n_items / 4);
        for (int n = 0; n < n_items; n++) begin
            if (n == pause_at && sender_gaps_on) wait_all_responses();
            send_random_request();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_capacity_in_use = '0;
        i_req_valid = 1'b0;
        i_req_type = REQ_GET;
        i_req_key = '0;
        i_req_value = '0;
        mismatch_count = 0;
        receiver_hold_cycles = 0;
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_value[i] = '0;
            tbl_rank[i] = 0;
        end
        tbl_count = 0;
        tbl_capacity = CAP_BITS'(CAP_RESET);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_capacity_one();
        test_capacity_zero();
        test_fill_and_evict();
        test_response_backpressure();
        test_random_requests(200, 5'd2);
        test_random_requests(200, 5'd16);
        test_random_requests(200, 5'd31);
        test_random_requests(200, 5'($urandom_range(3, 15)));
        test_random_requests(200, 5'd1);
        test_random_requests(200, 5'd17);
        wait_all_responses();
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b0;
        test_random_requests(200, 5'($urandom_range(5, 16)));

        wait_all_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        int idle_left;
        idle_left = 0;
        i_rsp_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (receiver_hold_cycles > 0) begin
                i_rsp_ready = 1'b0;
                receiver_hold_cycles--;
            end else if (idle_left > 0) begin
                i_rsp_ready = 1'b0;
                idle_left--;
            end else if (receiver_gaps_on && $urandom_range(0, 5) == 0) begin
                i_rsp_ready = 1'b0;
                idle_left = $urandom_range(1, 5) - 1;
            end else begin
                i_rsp_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cache_response want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_responses.size() == 0) begin
                $error("unexpected response: found=%0d read_value=%h evicted=%0d key=%h",
                       o_found, o_read_value, o_evicted, o_evicted_key);
                mismatch_count++;
            end else begin
                want = expected_responses.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_found);
                    mismatch_count++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, actual %h", want.read_value,
                           o_read_value);
                    mismatch_count++;
                end
                if (o_evicted !== want.evicted) begin
                    $error("evicted: expected %0d, actual %0d", want.evicted, o_evicted);
                    mismatch_count++;
                end
                if (o_evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %h, actual %h", want.evicted_key,
                           o_evicted_key);
                    mismatch_count++;
                end
            end
        end
    end

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
